### rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the integer to decimal ASCII block
// Character codes, BCD geometry, sequencer states and converter status.
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int BIN_W      = 32;             // input integer width
   localparam int DIGIT_W    = 4;              // one BCD digit
   localparam int NUM_DIGITS = 10;             // enough for 2147483648
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int IDX_W      = 4;              // digit index 0..9
   localparam int CHAR_W     = 8;
   localparam int STEP_BITS  = 4;              // input bits folded in per pass
   localparam int NUM_PASSES = BIN_W / STEP_BITS;
   localparam int PASS_W     = $clog2(NUM_PASSES);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;  // '9'
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;  // '-'

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;    // one-cycle pulse, BCD result valid
   } conv_status_type;

endpackage

### rtl/int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top: signed 32-bit integer to decimal ASCII text
// Emits '-' for negatives, then digits MSD first without leading zeros.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)        | side band
//  --------+-----+---------------------------+--------------------------
//  req_    | in  | [31:0] value (signed)     | -
//  rsp_    | out | [7:0]  char_code          | tlast = is_last
//
//  Steps: accept, run the BCD converter (4 bits per pass over the
//  shared add-3/shift unit), pick the leading digit, then send the
//  characters (1 to 11) as the receiver takes them.
//  req_tready is high only while idle. A stalled rsp_ holds its character.
//  Reset (synchronous, active high) returns the sequencer to idle.
//
module int_to_decimal_ascii_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_code
   output logic        rsp_tlast    // is_last
);

   itda_pkg::state_type            state_ff, state_in;
   logic                           neg_ff, neg_in;
   logic [itda_pkg::IDX_W-1:0]     idx_ff, idx_in;

   itda_pkg::conv_status_type      conv_status;
   logic [itda_pkg::BCD_W-1:0]     conv_bcd;
   logic                           conv_start;
   logic [itda_pkg::BIN_W-1:0]     mag;
   logic [itda_pkg::IDX_W-1:0]     lead_idx;
   logic [itda_pkg::DIGIT_W-1:0]   cur_digit;
   logic                           req_fire;
   logic                           rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // two's complement magnitude; the most negative value maps to 2^31
   assign mag = req_tdata[31] ? (~req_tdata + 32'd1) : req_tdata;

   itda_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .mag    (mag),
      .status (conv_status),
      .bcd    (conv_bcd)
   );

   // most significant nonzero digit; zero keeps index 0 so '0' goes out
   always_comb begin
      lead_idx = '0;
      for (int i = 1; i < itda_pkg::NUM_DIGITS; i++) begin
         if (conv_bcd[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] != '0) begin
            lead_idx = itda_pkg::IDX_W'(i);
         end
      end
   end

   assign cur_digit = conv_bcd[idx_ff*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];

   // next state
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      idx_in   = idx_ff;
      case (state_ff)
         itda_pkg::ST_IDLE: begin
            if (req_fire) begin
               neg_in   = req_tdata[31];
               state_in = itda_pkg::ST_CONVERT;
            end
         end
         itda_pkg::ST_CONVERT: begin
            if (conv_status.done) begin
               idx_in   = lead_idx;
               state_in = neg_ff ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGITS;
            end
         end
         itda_pkg::ST_SIGN: begin
            if (rsp_fire) begin
               state_in = itda_pkg::ST_DIGITS;
            end
         end
         itda_pkg::ST_DIGITS: begin
            if (rsp_fire) begin
               if (idx_ff == '0) begin
                  state_in = itda_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = itda_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = itda_pkg::CHAR_ZERO;
      rsp_tlast  = 1'b0;
      conv_start = 1'b0;
      case (state_ff)
         itda_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            conv_start = req_tvalid;
         end
         itda_pkg::ST_CONVERT: begin
         end
         itda_pkg::ST_SIGN: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = itda_pkg::CHAR_MINUS;
         end
         itda_pkg::ST_DIGITS: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = itda_pkg::CHAR_ZERO + {4'b0, cur_digit};
            rsp_tlast  = (idx_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itda_pkg::ST_IDLE;
         neg_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         neg_ff   <= neg_in;
         idx_ff   <= idx_in;
      end
   end

   // ---- checks ----
   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      conv_status.done |-> (state_ff == itda_pkg::ST_CONVERT))
      else $error("converter finished outside the convert state");

   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itda_pkg::ST_SIGN) |-> neg_ff)
      else $error("minus sign for a non-negative value");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!req_tready && !conv_status.busy))
      else $error("output while accepting or converting");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itda_pkg::ST_DIGITS) |->
         (rsp_tdata >= itda_pkg::CHAR_ZERO && rsp_tdata <= itda_pkg::CHAR_NINE))
      else $error("digit character out of range");

endmodule

### rtl/itda_conv.sv
// ----------------------------------------------------------------------------
// itda_conv: iterative binary to BCD converter
// Shift-and-add-3 over a 40-bit BCD register, four input bits per pass.
// ----------------------------------------------------------------------------
module itda_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [itda_pkg::BIN_W-1:0]    mag,
   output itda_pkg::conv_status_type     status,
   output logic [itda_pkg::BCD_W-1:0]    bcd
);

   logic [itda_pkg::BIN_W-1:0]  bin_ff, bin_in;
   logic [itda_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [itda_pkg::PASS_W-1:0] pass_ff, pass_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [itda_pkg::BCD_W-1:0]  step_bcd;

   function automatic logic [itda_pkg::DIGIT_W-1:0] adjust(
      input logic [itda_pkg::DIGIT_W-1:0] d);
      adjust = (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

   // one pass: STEP_BITS dependent add-3/shift steps on the digits
   always_comb begin
      logic [itda_pkg::BCD_W-1:0] t;
      t = bcd_ff;
      for (int k = 0; k < itda_pkg::STEP_BITS; k++) begin
         for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
            t[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
               adjust(t[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W]);
         end
         t = {t[itda_pkg::BCD_W-2:0], bin_ff[itda_pkg::BIN_W-1-k]};
      end
      step_bcd = t;
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      pass_in = pass_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = mag;
         bcd_in  = '0;
         pass_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = bin_ff << itda_pkg::STEP_BITS;
         bcd_in  = step_bcd;
         pass_in = pass_ff + 1'b1;
         if (pass_ff == itda_pkg::PASS_W'(itda_pkg::NUM_PASSES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pass_ff <= pass_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

### verif/tb_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii_top: self-checking bench for int_to_decimal_ascii_top
// Streams signed 32-bit values in and checks every ASCII character that comes
// out (code and last flag) against a local decimal-text predictor, under
// random and long back-pressure and input gaps.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii_top;

   localparam int DECIMAL_BASE = 10;
   localparam int MAX_DIGITS   = 10;     // 2147483648 has ten digits
   localparam int SETTLE_CYCLES = 32;    // settle time after the text drains
   localparam int QUIET_LIMIT  = 2000;   // cycles without any handshake
   localparam int STALL_CYCLES = 150;    // long receiver hold-off
   localparam int RANDOM_ITEMS = 140;    // per idling profile

   typedef struct packed {
      logic [itda_pkg::CHAR_W-1:0] char_code;
      logic                        is_last;
   } ascii_char_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] value (signed)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [7:0] char_code
   logic        rsp_tlast;    // is_last

   ascii_char_type expected_chars[$];   // characters still owed by the block
   int          error_count;
   int          quiet_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_request;    // set by a test, consumed by the receiver

   int_to_decimal_ascii_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8-unit clock period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor: decimal text of a two's complement value.
   // Magnitude is taken modulo 2^32, so the most negative value stays
   // 2147483648 and gives eleven characters.
   // ------------------------------------------------------------------------
   function automatic void spell_decimal(input logic [31:0] value);
      logic [31:0] magnitude;
      logic [3:0]  digit_buf [MAX_DIGITS];
      int          ndig;
      int          i;
      logic        negative;
      negative  = value[31];
      magnitude = negative ? (32'd0 - value) : value;
      ndig      = 0;
      // least significant digit first; zero still yields one digit
      do begin
         digit_buf[ndig] = 4'(magnitude % DECIMAL_BASE);
         magnitude       = magnitude / DECIMAL_BASE;
         ndig++;
      end while (magnitude != 0 && ndig < MAX_DIGITS);
      if (negative) begin
         expected_chars.push_back('{char_code: itda_pkg::CHAR_MINUS, is_last: 1'b0});
      end
      for (i = ndig - 1; i >= 0; i--) begin
         expected_chars.push_back(
            '{char_code: itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digit_buf[i]),
              is_last:   (i == 0)});
      end
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: on each rising edge, predict for an accepted value first,
   // then check an accepted character against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            spell_decimal(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character: code %0d last %0d", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.char_code) begin
                  $error("char_code mismatch: expected %0d actual %0d",
                         want.char_code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $error("is_last mismatch: expected %0d actual %0d",
                         want.is_last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** int_to_decimal_ascii_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random ready, or a counted hold-off when a test asks for one.
   always @(negedge clock) begin
      int hold_left;
      if (hold_off_request > 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sender: optional gap, then offer one value until it is taken.
   // Valid stays high between back-to-back items.
   // ------------------------------------------------------------------------
   task automatic push_value(input logic [31:0] value);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering, wait for every owed character, then let the block settle.
   task automatic drain_text();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Value with a chosen digit count and sign; now and then any 32-bit pattern.
   function automatic logic [31:0] pick_value();
      longint lo;
      longint hi;
      longint mag;
      int     ndig;
      logic   negative;
      int     k;
      if ($urandom_range(9) < 2) begin
         return $urandom;
      end
      ndig     = $urandom_range(1, MAX_DIGITS);
      negative = 1'($urandom_range(1));
      lo = 1;
      for (k = 1; k < ndig; k++) lo = lo * DECIMAL_BASE;
      hi = lo * DECIMAL_BASE - 1;
      if (ndig == 1) lo = 0;
      if (ndig == MAX_DIGITS) hi = negative ? 64'd2147483648 : 64'd2147483647;
      mag = lo + longint'($urandom_range(32'(hi - lo)));
      return negative ? 32'(-mag) : 32'(mag);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extremes, zero, digit-count boundaries and alternating bit patterns.
   task automatic test_extremes();
      logic [31:0] corner [$];
      int          n;
      corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd1234567890,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'hFFFF_FFF6, 32'd2147483640, 32'd7};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (n = 0; n < corner.size(); n++) push_value(corner[n]);
      drain_text();
   endtask

   // Random values under one idling profile.
   task automatic test_random_values(input int sender_pct, input int receiver_pct);
      int n;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (n = 0; n < RANDOM_ITEMS; n++) push_value(pick_value());
      drain_text();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so the block backs up and drops req_tready.
   task automatic test_output_stall();
      int n;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = STALL_CYCLES;
      for (n = 0; n < 12; n++) push_value(pick_value());
      drain_text();
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      error_count      = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_random_values(23, 70);
      test_random_values(70, 23);
      test_output_stall();
      test_random_values(0, 0);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("** int_to_decimal_ascii_top: PASSED **");
      end else begin
         $display("** int_to_decimal_ascii_top: FAILED **");
      end
      $finish;
   end

endmodule

### int_to_decimal_ascii_top.f
rtl/itda_pkg.sv
rtl/itda_conv.sv
rtl/int_to_decimal_ascii_top.sv
verif/tb_int_to_decimal_ascii_top.sv
